[design/bir_pkg.sv]
`timescale 1ns / 1ps

package bir_pkg;

	// Command codes carried on tuser of the input stream.
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y    = 2'd3;
	localparam int CFG_DATA_W = 26;

	// Field widths.
	localparam int SIZE_REG_W = 10;
	localparam int SCALE_W    = 26;
	localparam int COORD_W    = 12;
	localparam int POS_W      = COORD_W + SCALE_W;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int FRAC_W     = 16;
	localparam int WT_W       = FRAC_W + 1;
	localparam int ACC_W      = 24;
	localparam int OUT_CH_W   = 16;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;

	// Distance kept below the last source column or row, in Q.16 units.
	localparam int CLAMP_MARGIN = 66;

	// One stored source pixel, red in the top byte.
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	// Sequencer controls for the blend unit.
	typedef struct packed {
		logic       clr;
		logic       wt_en;
		logic [1:0] corner;
	} blend_ctl_t;

endpackage

[design/bir_frame_store.sv]
`timescale 1ns / 1ps

module bir_frame_store #(
	parameter int DEPTH = 262144,
	parameter int AW    = 18
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  bir_pkg::pixel_t        wdata,
	input  logic [AW-1:0]          raddr,
	output bir_pkg::pixel_t        rdata
);

	bir_pkg::pixel_t mem [DEPTH];

	// Write port for pixel loads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port for neighbor fetches.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[design/bir_axis.sv]
`timescale 1ns / 1ps

module bir_axis #(
	parameter int MAX_SIZE = 512,
	parameter int SW       = 10,
	parameter int IW       = 9
) (
	input  logic                                clk,
	input  logic                                cap,
	input  logic [bir_pkg::COORD_W-1:0]         coord,
	input  logic [bir_pkg::SCALE_W-1:0]         scale,
	input  logic [bir_pkg::SIZE_REG_W-1:0]      size_reg,
	output logic [SW-1:0]                       eff_size,
	output logic [IW-1:0]                       idx_s2,
	output logic [bir_pkg::FRAC_W-1:0]          frac_s2
);

	logic [bir_pkg::POS_W-1:0] pos_s1;
	logic [SW+15:0]            top_val;
	logic [bir_pkg::POS_W-1:0] clamped;

	// The size register saturates to the range the store can hold.
	always_comb begin
		if (size_reg < bir_pkg::SIZE_REG_W'(2)) begin
			eff_size = SW'(2);
		end else if (32'(size_reg) > MAX_SIZE) begin
			eff_size = SW'(MAX_SIZE);
		end else begin
			eff_size = SW'(size_reg);
		end
	end

	// Source position in Q.16, captured as the item is accepted.
	always_ff @(posedge clk) begin
		if (cap) begin
			pos_s1 <= bir_pkg::POS_W'(coord) * bir_pkg::POS_W'(scale);
		end
	end

	// Clamp below the last pixel, then split into index and fraction.
	always_comb begin
		top_val = {eff_size - SW'(1), 16'h0000} - (SW+16)'(bir_pkg::CLAMP_MARGIN);
		if (pos_s1 > bir_pkg::POS_W'(top_val)) begin
			clamped = bir_pkg::POS_W'(top_val);
		end else begin
			clamped = pos_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2  <= clamped[bir_pkg::FRAC_W +: IW];
		frac_s2 <= clamped[bir_pkg::FRAC_W-1:0];
	end

endmodule

[design/bir_blend.sv]
`timescale 1ns / 1ps

module bir_blend (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bir_pkg::blend_ctl_t               ctl,
	input  logic [bir_pkg::FRAC_W-1:0]        fx,
	input  logic [bir_pkg::FRAC_W-1:0]        fy,
	input  bir_pkg::pixel_t                   pix,
	output logic [bir_pkg::OUT_CH_W-1:0]      red,
	output logic [bir_pkg::OUT_CH_W-1:0]      green,
	output logic [bir_pkg::OUT_CH_W-1:0]      blue
);

	logic [bir_pkg::WT_W-1:0]   fac_x;
	logic [bir_pkg::WT_W-1:0]   fac_y;
	logic [2*bir_pkg::WT_W-1:0] wt_prod;
	logic [bir_pkg::WT_W-1:0]   wt_q;
	logic                       acc_en_q;
	logic [bir_pkg::ACC_W-1:0]  acc_r_q;
	logic [bir_pkg::ACC_W-1:0]  acc_g_q;
	logic [bir_pkg::ACC_W-1:0]  acc_b_q;

	// Weight of the current corner: fraction or its complement on each axis.
	always_comb begin
		fac_x = ctl.corner[0] ? bir_pkg::WT_W'(fx) : (17'h10000 - bir_pkg::WT_W'(fx));
		fac_y = ctl.corner[1] ? bir_pkg::WT_W'(fy) : (17'h10000 - bir_pkg::WT_W'(fy));
		wt_prod = (2*bir_pkg::WT_W)'(fac_x) * (2*bir_pkg::WT_W)'(fac_y);
	end

	// The weight is registered to line up with the registered store read.
	always_ff @(posedge clk) begin
		if (ctl.wt_en) begin
			wt_q <= wt_prod[bir_pkg::FRAC_W +: bir_pkg::WT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_q <= 1'b0;
		end else begin
			acc_en_q <= ctl.wt_en;
		end
	end

	// Per-channel multiply and accumulate over the four neighbors.
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
		end else if (acc_en_q) begin
			acc_r_q <= acc_r_q + bir_pkg::ACC_W'(bir_pkg::ACC_W'(pix.red) * bir_pkg::ACC_W'(wt_q));
			acc_g_q <= acc_g_q + bir_pkg::ACC_W'(bir_pkg::ACC_W'(pix.green) * bir_pkg::ACC_W'(wt_q));
			acc_b_q <= acc_b_q + bir_pkg::ACC_W'(bir_pkg::ACC_W'(pix.blue) * bir_pkg::ACC_W'(wt_q));
		end
	end

	// Q8.8 result drops the low eight bits.
	assign red   = acc_r_q[bir_pkg::ACC_W-1:8];
	assign green = acc_g_q[bir_pkg::ACC_W-1:8];
	assign blue  = acc_b_q[bir_pkg::ACC_W-1:8];

endmodule

[design/bilinear_image_resampler_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tuser: cmd; tdata: coord_x, coord_y, in_red, in_green, in_blue
// m_axis    out        tdata: out_red, out_green, out_blue
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// A load item writes the frame store directly when it is accepted.
// A sample item runs through position multiply, clamp, four reads of
// the single store read port (one neighbor each), one accumulate, one output.
// The result waits in an output register; the next item is accepted while it
// is pending, and a new result waits only if that register is still full.
// Reset clears control state; the frame store has no reset and holds garbage
// until written.

module bilinear_image_resampler_unit #(
	parameter int MAX_SRC_WIDTH  = 512,
	parameter int MAX_SRC_HEIGHT = 512
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [11:0] coord_x, [23:12] coord_y, [31:24] in_red, [39:32] in_green, [47:40] in_blue
	input  logic [bir_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// [0] cmd
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] out_red, [31:16] out_green, [47:32] out_blue
	output logic [bir_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [bir_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bir_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int SWX   = $clog2(MAX_SRC_WIDTH + 1);
	localparam int SWY   = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int IWX   = $clog2(MAX_SRC_WIDTH);
	localparam int IWY   = $clog2(MAX_SRC_HEIGHT);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOC   = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]                          state_q;
	logic [1:0]                          corner_q;
	logic [bir_pkg::SIZE_REG_W-1:0]      src_width_q;
	logic [bir_pkg::SIZE_REG_W-1:0]      src_height_q;
	logic [bir_pkg::SCALE_W-1:0]         scale_x_q;
	logic [bir_pkg::SCALE_W-1:0]         scale_y_q;
	logic                                out_valid_q;
	logic [bir_pkg::OUT_DATA_W-1:0]      out_data_q;

	logic [bir_pkg::COORD_W-1:0]         coord_x;
	logic [bir_pkg::COORD_W-1:0]         coord_y;
	bir_pkg::pixel_t                     in_pix;
	logic                                in_acc;
	logic                                smp_acc;
	logic [SWX-1:0]                      w_eff;
	logic [SWY-1:0]                      h_eff;
	logic [IWX-1:0]                      x0_s2;
	logic [IWY-1:0]                      y0_s2;
	logic [bir_pkg::FRAC_W-1:0]          fx_s2;
	logic [bir_pkg::FRAC_W-1:0]          fy_s2;
	logic                                mem_we;
	logic [AW-1:0]                       waddr;
	logic [AW-1:0]                       raddr;
	logic [IWX-1:0]                      rx;
	logic [IWY-1:0]                      ry;
	bir_pkg::pixel_t                     rdata;
	bir_pkg::blend_ctl_t                 bctl;
	logic [bir_pkg::OUT_CH_W-1:0]        res_r;
	logic [bir_pkg::OUT_CH_W-1:0]        res_g;
	logic [bir_pkg::OUT_CH_W-1:0]        res_b;
	logic                                out_free;

	// Input item unpacking.
	assign coord_x      = s_axis_tdata[11:0];
	assign coord_y      = s_axis_tdata[23:12];
	assign in_pix.red   = s_axis_tdata[31:24];
	assign in_pix.green = s_axis_tdata[39:32];
	assign in_pix.blue  = s_axis_tdata[47:40];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign smp_acc       = in_acc && (s_axis_tuser == bir_pkg::CMD_SAMPLE);
	assign out_free      = !out_valid_q || m_axis_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= bir_pkg::SIZE_REG_W'(512);
			src_height_q <= bir_pkg::SIZE_REG_W'(512);
			scale_x_q    <= bir_pkg::SCALE_W'(65536);
			scale_y_q    <= bir_pkg::SCALE_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				bir_pkg::CFG_SRC_WIDTH:  src_width_q  <= cfg_data[bir_pkg::SIZE_REG_W-1:0];
				bir_pkg::CFG_SRC_HEIGHT: src_height_q <= cfg_data[bir_pkg::SIZE_REG_W-1:0];
				bir_pkg::CFG_SCALE_X:    scale_x_q    <= cfg_data;
				bir_pkg::CFG_SCALE_Y:    scale_y_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Per-axis position, clamp and split.
	bir_axis #(.MAX_SIZE(MAX_SRC_WIDTH), .SW(SWX), .IW(IWX)) u_axis_x (
		.clk      (clk),
		.cap      (smp_acc),
		.coord    (coord_x),
		.scale    (scale_x_q),
		.size_reg (src_width_q),
		.eff_size (w_eff),
		.idx_s2   (x0_s2),
		.frac_s2  (fx_s2)
	);

	bir_axis #(.MAX_SIZE(MAX_SRC_HEIGHT), .SW(SWY), .IW(IWY)) u_axis_y (
		.clk      (clk),
		.cap      (smp_acc),
		.coord    (coord_y),
		.scale    (scale_y_q),
		.size_reg (src_height_q),
		.eff_size (h_eff),
		.idx_s2   (y0_s2),
		.frac_s2  (fy_s2)
	);

	// Loads inside the configured image go straight to the store.
	assign mem_we = in_acc && (s_axis_tuser == bir_pkg::CMD_LOAD) &&
			(32'(coord_x) < 32'(w_eff)) && (32'(coord_y) < 32'(h_eff));
	assign waddr  = AW'(coord_y[IWY-1:0]) * AW'(MAX_SRC_WIDTH) + AW'(coord_x[IWX-1:0]);

	// Neighbor address: corner bit 0 steps in x, bit 1 steps in y.
	assign rx    = x0_s2 + IWX'(corner_q[0]);
	assign ry    = y0_s2 + IWY'(corner_q[1]);
	assign raddr = AW'(ry) * AW'(MAX_SRC_WIDTH) + AW'(rx);

	bir_frame_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (in_pix),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign bctl.clr    = (state_q == S_LOC);
	assign bctl.wt_en  = (state_q == S_READ);
	assign bctl.corner = corner_q;

	bir_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (bctl),
		.fx     (fx_s2),
		.fy     (fy_s2),
		.pix    (rdata),
		.red    (res_r),
		.green  (res_g),
		.blue   (res_b)
	);

	// Sample sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			corner_q <= 2'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (smp_acc) begin
						state_q <= S_LOC;
					end
				end
				S_LOC: begin
					state_q  <= S_READ;
					corner_q <= 2'd0;
				end
				S_READ: begin
					corner_q <= corner_q + 2'd1;
					if (corner_q == 2'd3) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			out_data_q <= {res_b, res_g, res_r};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A sample item starts the sequencer on the next cycle.
	a_smp_start: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc |=> (state_q == S_LOC))
		else $error("sample item did not start the sequencer");

	// The store is written only while no sample is being read.
	a_no_wr_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_IDLE))
		else $error("store write during a sample");

	// The clamp keeps the right and lower neighbors inside the image.
	a_clamp_x: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> ((32'(x0_s2) + 1) < 32'(w_eff)))
		else $error("x neighbor outside the image");

	a_clamp_y: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> ((32'(y0_s2) + 1) < 32'(h_eff)))
		else $error("y neighbor outside the image");

	// The corner counter has wrapped back to zero by the drain state.
	a_corner_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> (corner_q == 2'd0))
		else $error("corner counter did not wrap");

endmodule

[verif/tb_bilinear_image_resampler_unit.sv]
`timescale 1ns / 1ps

module tb_bilinear_image_resampler_unit;
	import bir_pkg::*;

	localparam int MAX_W           = 512;
	localparam int MAX_H           = 512;
	localparam int DRAIN_CYCLES    = 16;
	localparam int STALL_LIMIT     = 4000;
	localparam int TOTAL_ITEMS     = 1000;
	localparam int MIN_PHASES      = 4;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int MAX_REPORTS     = 60;
	localparam logic [SCALE_W-1:0] MAX_SCALE  = 26'd33554432;
	localparam logic [SCALE_W-1:0] UNIT_SCALE = 26'd65536;
	localparam logic [SCALE_W-1:0] HALF_SCALE = 26'd32768;
	localparam logic [COORD_W-1:0] TOP_COORD  = 12'd4095;

	// One interpolated result, red in the lowest bits as on m_axis_tdata.
	typedef struct packed {
		logic [OUT_CH_W-1:0] blue;
		logic [OUT_CH_W-1:0] green;
		logic [OUT_CH_W-1:0] red;
	} rgb_q88_t;

	// Shadow of the frame store and registers, plus the queue of expected samples.
	class resampler_scoreboard;
		pixel_t image [int unsigned];
		logic [SIZE_REG_W-1:0] width_reg;
		logic [SIZE_REG_W-1:0] height_reg;
		logic [SCALE_W-1:0] scale_x_reg;
		logic [SCALE_W-1:0] scale_y_reg;
		rgb_q88_t expected_rgb [$];
		int errors;
		int loads;
		int skipped;
		int samples;
		int results;

		function new();
			width_reg   = 10'd512;
			height_reg  = 10'd512;
			scale_x_reg = UNIT_SCALE;
			scale_y_reg = UNIT_SCALE;
		endfunction

		function int unsigned clip_size(logic [SIZE_REG_W-1:0] r, int unsigned lim);
			if (r < 2)
				return 2;
			if (r > lim)
				return lim;
			return r;
		endfunction

		function int unsigned eff_width();
			return clip_size(width_reg, MAX_W);
		endfunction

		function int unsigned eff_height();
			return clip_size(height_reg, MAX_H);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
			CFG_SRC_WIDTH:  width_reg   = val[SIZE_REG_W-1:0];
			CFG_SRC_HEIGHT: height_reg  = val[SIZE_REG_W-1:0];
			CFG_SCALE_X:    scale_x_reg = val[SCALE_W-1:0];
			CFG_SCALE_Y:    scale_y_reg = val[SCALE_W-1:0];
			default: ;
			endcase
		endfunction

		// Clamp a Q.16 position below the last pixel and split it into
		// the two neighbor indexes and the fraction between them.
		function void split_pos(input longint unsigned pos, input int unsigned size,
				output int unsigned lo, output int unsigned hi, output int unsigned frac);
			longint unsigned top;
			longint unsigned clamped;
			top = size - 1;
			top = (top << 16) - CLAMP_MARGIN;
			clamped = (pos > top) ? top : pos;
			lo = 32'(clamped >> 16);
			frac = 32'(clamped & 64'hFFFF);
			hi = (lo + 1 < size - 1) ? lo + 1 : size - 1;
		endfunction

		function pixel_t read_px(int unsigned x, int unsigned y);
			int unsigned addr;
			addr = y * MAX_W + x;
			if (image.exists(addr))
				return image[addr];
			return '0;
		endfunction

		// Bilinear blend of the four neighbors of one destination pixel.
		function rgb_q88_t blend_sample(int unsigned cx, int unsigned cy);
			longint unsigned pos_x, pos_y;
			longint unsigned gx, gy;
			longint unsigned wt [4];
			longint unsigned acc_r, acc_g, acc_b;
			int unsigned x0, x1, y0, y1, fx, fy;
			pixel_t px [4];
			rgb_q88_t res;
			pos_x = cx;
			pos_x = pos_x * scale_x_reg;
			pos_y = cy;
			pos_y = pos_y * scale_y_reg;
			split_pos(pos_x, eff_width(), x0, x1, fx);
			split_pos(pos_y, eff_height(), y0, y1, fy);
			gx = 65536 - fx;
			gy = 65536 - fy;
			wt[0] = (gx * gy) >> 16;
			wt[1] = (fx * gy) >> 16;
			wt[2] = (gx * fy) >> 16;
			wt[3] = (fx * fy) >> 16;
			px[0] = read_px(x0, y0);
			px[1] = read_px(x1, y0);
			px[2] = read_px(x0, y1);
			px[3] = read_px(x1, y1);
			acc_r = 0;
			acc_g = 0;
			acc_b = 0;
			for (int k = 0; k < 4; k++) begin
				acc_r += px[k].red * wt[k];
				acc_g += px[k].green * wt[k];
				acc_b += px[k].blue * wt[k];
			end
			res.red   = OUT_CH_W'(acc_r >> 8);
			res.green = OUT_CH_W'(acc_g >> 8);
			res.blue  = OUT_CH_W'(acc_b >> 8);
			return res;
		endfunction

		// Called for every accepted input item.
		function void note_input(logic cmd, logic [IN_DATA_W-1:0] d);
			int unsigned cx, cy;
			pixel_t p;
			cx = d[COORD_W-1:0];
			cy = d[2*COORD_W-1:COORD_W];
			if (cmd == CMD_SAMPLE) begin
				samples++;
				expected_rgb.push_back(blend_sample(cx, cy));
			end else if (cx < eff_width() && cy < eff_height()) begin
				loads++;
				p.red   = d[31:24];
				p.green = d[39:32];
				p.blue  = d[47:40];
				image[cy * MAX_W + cx] = p;
			end else begin
				skipped++;
			end
		endfunction

		function void compare_field(string name, logic [OUT_CH_W-1:0] want,
				logic [OUT_CH_W-1:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			end
		endfunction

		// Called for every accepted result item.
		function void check_result(logic [OUT_DATA_W-1:0] d);
			rgb_q88_t got, want;
			got = d;
			results++;
			if (expected_rgb.size() == 0) begin
				errors++;
				$display("%0t: result %h arrived with no sample pending", $time, d);
				return;
			end
			want = expected_rgb.pop_front();
			compare_field("out_red", want.red, got.red);
			compare_field("out_green", want.green, got.green);
			compare_field("out_blue", want.blue, got.blue);
		endfunction

		function void note_leftovers();
			if (expected_rgb.size() != 0) begin
				errors += expected_rgb.size();
				$display("%0t: %0d samples never produced a result", $time,
					expected_rgb.size());
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	resampler_scoreboard sb;
	bit filled [MAX_W*MAX_H];
	int unsigned cur_w, cur_h;
	int unsigned dest_w, dest_h;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int sent_count = 0;
	int settings_count = 0;
	int idle_cycles = 0;

	bilinear_image_resampler_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// Receiver: stall at random per cycle while a stall rate is set.
	always @(negedge clk) begin
		m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	// Monitor both streams and guard against a hung block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Present one item at a falling edge and hold it until it is taken.
	task automatic send_item(input logic cmd, input logic [COORD_W-1:0] x, y,
			input logic [CH_W-1:0] r, g, b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {b, g, r, y, x};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic load_pixel(input int unsigned x, y, input logic [CH_W-1:0] r, g, b);
		send_item(CMD_LOAD, COORD_W'(x), COORD_W'(y), r, g, b);
		filled[y * MAX_W + x] = 1'b1;
	endtask

	task automatic load_random(input int unsigned x, y);
		load_pixel(x, y, CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
			CH_W'($urandom_range(255)));
	endtask

	// A load that falls outside the current image and must be dropped.
	task automatic skip_load();
		logic [COORD_W-1:0] x, y;
		if ($urandom_range(1)) begin
			x = COORD_W'($urandom_range(TOP_COORD, cur_w));
			y = COORD_W'($urandom_range(TOP_COORD));
		end else begin
			x = COORD_W'($urandom_range(TOP_COORD));
			y = COORD_W'($urandom_range(TOP_COORD, cur_h));
		end
		send_item(CMD_LOAD, x, y, CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
			CH_W'($urandom_range(255)));
	endtask

	task automatic sample_at(input logic [COORD_W-1:0] x, y);
		send_item(CMD_SAMPLE, x, y, CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
			CH_W'($urandom_range(255)));
	endtask

	// Wait until every sample has come back and the pipeline has emptied.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_rgb.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [SIZE_REG_W-1:0] wr, hr,
			input logic [SCALE_W-1:0] sx, sy);
		settle();
		write_cfg(CFG_SRC_WIDTH, CFG_DATA_W'(wr));
		write_cfg(CFG_SRC_HEIGHT, CFG_DATA_W'(hr));
		write_cfg(CFG_SCALE_X, sx);
		write_cfg(CFG_SCALE_Y, sy);
		cfg_we <= 1'b0;
		cur_w = sb.eff_width();
		cur_h = sb.eff_height();
		settings_count++;
	endtask

	// Make sure every pixel of the current image holds a loaded value.
	task automatic fill_image();
		for (int unsigned y = 0; y < cur_h; y++) begin
			for (int unsigned x = 0; x < cur_w; x++) begin
				if (!filled[y * MAX_W + x])
					load_random(x, y);
				if ($urandom_range(31) == 0)
					skip_load();
			end
		end
	endtask

	// Load only the pixels where the first two and last two columns cross the
	// first two and last two rows, which is all a zero or a saturating scale can reach.
	task automatic load_edges();
		int unsigned xs [4];
		int unsigned ys [4];
		xs = '{0, 1, cur_w - 2, cur_w - 1};
		ys = '{0, 1, cur_h - 2, cur_h - 1};
		foreach (ys[j]) begin
			foreach (xs[i]) begin
				if (!filled[ys[j] * MAX_W + xs[i]])
					load_random(xs[i], ys[j]);
			end
		end
	endtask

	// Mostly a scale that maps a destination size onto the image, else zero, the largest, unit or a random scale.
	task automatic pick_scale(input int unsigned size, output logic [SCALE_W-1:0] scale,
			output int unsigned dest);
		int unsigned mode;
		longint unsigned span;
		mode = $urandom_range(9);
		dest = $urandom_range(64, 1);
		case (mode)
		0: scale = '0;
		1: scale = MAX_SCALE;
		2: scale = UNIT_SCALE;
		3: scale = SCALE_W'($urandom_range(MAX_SCALE));
		default: begin
			dest = $urandom_range(4 * size, 1);
			span = size;
			span = (span << 16) / dest;
			scale = SCALE_W'(span);
		end
		endcase
	endtask

	task automatic random_coord(input int unsigned dest, output logic [COORD_W-1:0] c);
		if ($urandom_range(9) < 7)
			c = COORD_W'($urandom_range(dest + 1));
		else
			c = COORD_W'($urandom_range(TOP_COORD));
	endtask

	task automatic set_idle(input int mode);
		case (mode)
		0: begin
			send_idle_pct = 0;
			stall_pct = 0;
		end
		1: begin
			send_idle_pct = 58;
			stall_pct = 0;
		end
		2: begin
			send_idle_pct = 0;
			stall_pct = 58;
		end
		default: begin
			send_idle_pct = 34;
			stall_pct = 34;
		end
		endcase
	endtask

	initial begin
		logic [SIZE_REG_W-1:0] wr, hr;
		logic [SCALE_W-1:0] sx, sy;
		logic [COORD_W-1:0] x, y;
		int phase;
		int pick;

		sb = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_LOAD;
		cfg_we        = 1'b0;
		cfg_index     = CFG_SRC_WIDTH;
		cfg_data      = '0;
		repeat (2)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Smallest image through size registers below range, zero scale.
		set_config(10'd0, 10'd1, '0, '0);
		load_pixel(0, 0, 8'hFF, 8'hFF, 8'hFF);
		load_pixel(1, 0, 8'h00, 8'h00, 8'h00);
		load_pixel(0, 1, 8'hFF, 8'h00, 8'h80);
		load_pixel(1, 1, 8'h01, 8'hFE, 8'h7F);
		send_item(CMD_LOAD, 2, 0, 8'hFF, 8'hFF, 8'hFF);
		send_item(CMD_LOAD, TOP_COORD, TOP_COORD, 8'hFF, 8'hFF, 8'hFF);
		sample_at(0, 0);
		sample_at(TOP_COORD, TOP_COORD);

		// Largest scale drives the position into the clamp.
		set_config(10'd2, 10'd2, MAX_SCALE, MAX_SCALE);
		sample_at(0, 0);
		sample_at(1, 1);
		sample_at(TOP_COORD, 0);

		// Half-pixel steps give equal weights and a clamped right edge.
		set_config(10'd2, 10'd2, HALF_SCALE, HALF_SCALE);
		sample_at(1, 1);
		sample_at(3, 1);
		sample_at(1, 0);

		// Width register above range saturates to the widest image.
		set_config(10'd1023, 10'd2, MAX_SCALE, HALF_SCALE);
		load_edges();
		send_item(CMD_LOAD, COORD_W'(MAX_W), 0, 8'hFF, 8'hFF, 8'hFF);
		sample_at(0, 0);
		sample_at(1, 1);
		sample_at(TOP_COORD, 1);

		// Height register above range, width below range.
		set_config(10'd1, 10'd1023, HALF_SCALE, MAX_SCALE);
		load_edges();
		send_item(CMD_LOAD, 0, COORD_W'(MAX_H), 8'hFF, 8'hFF, 8'hFF);
		sample_at(0, 0);
		sample_at(1, 1);
		sample_at(1, TOP_COORD);

		// Random phases, each with its own image size, scales and idling.
		phase = 0;
		while (sent_count < TOTAL_ITEMS || phase < MIN_PHASES) begin
			wr = SIZE_REG_W'($urandom_range(24));
			hr = SIZE_REG_W'($urandom_range(24));
			pick_scale(sb.clip_size(wr, MAX_W), sx, dest_w);
			pick_scale(sb.clip_size(hr, MAX_H), sy, dest_h);
			set_config(wr, hr, sx, sy);
			set_idle(phase % 4);
			fill_image();
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					random_coord(dest_w, x);
					random_coord(dest_h, y);
					sample_at(x, y);
				end else if (pick < 85) begin
					load_random($urandom_range(cur_w - 1), $urandom_range(cur_h - 1));
				end else begin
					skip_load();
				end
			end
			phase++;
		end

		settle();
		sb.note_leftovers();
		$display("Covered %0d pixel loads, %0d dropped loads and %0d samples",
			sb.loads, sb.skipped, sb.samples);
		$display("over %0d register settings; %0d results compared.",
			settings_count, sb.results);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
design/bir_pkg.sv
design/bir_frame_store.sv
design/bir_axis.sv
design/bir_blend.sv
design/bilinear_image_resampler_unit.sv
verif/tb_bilinear_image_resampler_unit.sv
